@@ src/varint_gap_decoder_core_defines.svh @@
// Assertion macros shared by the checker.
`ifndef VARINT_GAP_DECODER_CORE_DEFINES_SVH
`define VARINT_GAP_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define VGD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("vgd check failed");

// Next-cycle implication, ignored while reset is asserted.
`define VGD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("vgd check failed");

// Next-cycle implication that also holds through reset.
`define VGD_ASSERT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("vgd check failed");

`endif

@@ src/vgd_pkg.sv @@
package vgd_pkg;

    localparam int VERTEX_BITS    = 32;
    localparam int EDGE_BITS      = 32;
    localparam int SOURCE_BITS    = 32;
    localparam int BYTE_BITS      = 8;
    localparam int SHIFT_W        = 6;
    localparam int GROUP_BITS     = 7;
    localparam int FIRST_MAG_BITS = 6;
    localparam int CONT_BIT       = 7;
    localparam int SIGN_BIT       = 6;

    localparam logic [SHIFT_W-1:0] SHIFT_MAX   = '1;
    localparam logic [SHIFT_W-1:0] FIRST_SHIFT = SHIFT_W'(FIRST_MAG_BITS);

    typedef logic [VERTEX_BITS-1:0] vertex_t;
    typedef logic [SHIFT_W-1:0]     shift_t;

    typedef struct packed {
        logic [BYTE_BITS-1:0]   code_byte;
        logic                   list_start;
        logic [SOURCE_BITS-1:0] source_vertex;
    } vgd_in_t;

    typedef struct packed {
        logic [EDGE_BITS-1:0] edge_value;
        logic                 first_of_list;
    } vgd_out_t;

    // Byte held in the input register
    typedef struct packed {
        logic    valid;
        vgd_in_t item;
    } vgd_stage_t;

    // Result offered to the output register
    typedef struct packed {
        logic     valid;
        vgd_out_t data;
    } vgd_res_t;

endpackage

@@ src/vgd_in_stage.sv @@
module vgd_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  vgd_pkg::vgd_in_t    s_data,
    input  logic                advance,
    output vgd_pkg::vgd_stage_t stage
);
    import vgd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    vgd_in_t item_reg;

    // Take a new byte when the register is empty or the held one leaves this cycle
    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

@@ src/vgd_decode.sv @@
module vgd_decode (
    input  logic                aclk,
    input  logic                aresetn,
    input  vgd_pkg::vgd_stage_t stage,
    input  logic                out_free,
    output logic                advance,
    output vgd_pkg::vgd_res_t   res
);
    import vgd_pkg::*;

    vertex_t accum_reg, accum_next;
    shift_t  shift_reg, shift_next;
    logic    first_reg, first_next;
    logic    neg_reg,   neg_next;
    logic    mid_reg,   mid_next;
    vertex_t prev_reg,  prev_next;
    vertex_t src_reg,   src_next;

    logic [BYTE_BITS-1:0] b;
    logic                 cont;
    vertex_t              acc_base;
    shift_t               shift_base;
    vertex_t              acc_cur;
    shift_t               shift_cur;
    logic [SHIFT_W:0]     shift_sum;
    logic                 first_cur;
    logic                 neg_cur;
    vertex_t              src_cur;
    vertex_t              sum_base;
    vertex_t              addend;
    logic                 sub;
    vertex_t              val;

    assign b    = stage.item.code_byte;
    assign cont = b[CONT_BIT];

    // Continuation bytes never stall on the output side
    assign advance = stage.valid && (cont || out_free);

    always_comb begin
        acc_base   = mid_reg ? accum_reg : '0;
        shift_base = mid_reg ? shift_reg : '0;
        shift_sum  = {1'b0, shift_base} + (SHIFT_W + 1)'(GROUP_BITS);
        if (stage.item.list_start) begin
            src_cur   = VERTEX_BITS'(stage.item.source_vertex);
            first_cur = 1'b1;
            neg_cur   = b[SIGN_BIT];
            acc_cur   = VERTEX_BITS'(b[FIRST_MAG_BITS-1:0]);
            shift_cur = FIRST_SHIFT;
        end else begin
            src_cur   = src_reg;
            first_cur = mid_reg && first_reg;
            neg_cur   = neg_reg;
            // Groups past the top of the word shift out to zero
            acc_cur   = acc_base | (VERTEX_BITS'(b[GROUP_BITS-1:0]) << shift_base);
            if (cont) begin
                shift_cur = (shift_sum > (SHIFT_W + 1)'(SHIFT_MAX)) ? SHIFT_MAX
                                                                      : shift_sum[SHIFT_W-1:0];
            end else begin
                shift_cur = shift_base;
            end
        end
    end

    // One adder: source +/- magnitude for the first edge, previous + gap after
    always_comb begin
        sub      = first_cur && neg_cur;
        sum_base = first_cur ? src_cur : prev_reg;
        addend   = sub ? ~acc_cur : acc_cur;
        val      = sum_base + addend + VERTEX_BITS'(sub);
    end

    always_comb begin
        accum_next = accum_reg;
        shift_next = shift_reg;
        first_next = first_reg;
        neg_next   = neg_reg;
        mid_next   = mid_reg;
        prev_next  = prev_reg;
        src_next   = src_reg;
        if (advance) begin
            neg_next = neg_cur;
            src_next = src_cur;
            if (cont) begin
                accum_next = acc_cur;
                shift_next = shift_cur;
                first_next = first_cur;
                mid_next   = 1'b1;
            end else begin
                accum_next = '0;
                shift_next = '0;
                first_next = 1'b0;
                mid_next   = 1'b0;
                prev_next  = val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accum_reg <= '0;
            shift_reg <= '0;
            first_reg <= 1'b0;
            neg_reg   <= 1'b0;
            mid_reg   <= 1'b0;
            prev_reg  <= '0;
            src_reg   <= '0;
        end else begin
            accum_reg <= accum_next;
            shift_reg <= shift_next;
            first_reg <= first_next;
            neg_reg   <= neg_next;
            mid_reg   <= mid_next;
            prev_reg  <= prev_next;
            src_reg   <= src_next;
        end
    end

    assign res.valid              = stage.valid && !cont;
    assign res.data.edge_value    = EDGE_BITS'(val);
    assign res.data.first_of_list = first_cur;

endmodule

@@ src/vgd_out_stage.sv @@
module vgd_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  vgd_pkg::vgd_res_t res,
    output logic              out_free,
    output logic              m_valid,
    input  logic              m_ready,
    output vgd_pkg::vgd_out_t m_data
);
    import vgd_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    vgd_out_t data_reg;
    logic     load;

    assign out_free = !valid_reg || m_ready;
    assign load     = res.valid && out_free;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res.data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

@@ src/varint_gap_decoder_core.sv @@
// Varint gap decoder for compressed adjacency lists.
// Input channel (s_valid/s_ready/s_data): one transaction per stream byte.
//   Set list_start on the first byte of a list and give its source vertex
//   with that byte; the byte also opens the first edge (6 magnitude bits,
//   sign in bit 6, continue in bit 7). Later edges are 7-bit varint gaps
//   added to the previous edge. A zero gap must be sent as one 0x00 byte.
// Result channel (m_valid/m_ready/m_data): one transaction per completed
//   edge, issued for the byte with bit 7 clear, carrying the target vertex
//   and a first_of_list flag. Continuation bytes produce nothing.
// Path: the last byte of an edge waits in the input register, is decoded
//   combinationally, and its result is loaded into the result register once it has room.
// Throughput: one byte per cycle while finished edges find the result register
//   free. The limit is the decode loop: group shift, OR into the accumulator, one 32-bit add.
// Stall: when m_ready is low the result register holds; one more byte can
//   wait in the input register and continuation bytes keep draining, so
//   s_ready drops only when a finished edge finds the result register full.
// Reset (aresetn low, synchronous): drop any byte or result in flight and
//   clear the decode state; gaps before the first list start add to zero.
module varint_gap_decoder_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  vgd_pkg::vgd_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output vgd_pkg::vgd_out_t m_data
);
    import vgd_pkg::*;

    vgd_stage_t stage;
    vgd_res_t   res;
    logic       advance;
    logic       out_free;

    // Hold the accepted byte for the decode stage
    vgd_in_stage u_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .advance (advance),
        .stage   (stage)
    );

    // Assemble the varint and resolve the edge against source or previous edge
    vgd_decode u_dec (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .stage    (stage),
        .out_free (out_free),
        .advance  (advance),
        .res      (res)
    );

    // Register the finished edge toward the receiver
    vgd_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res      (res),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

@@ src/vgd_checker.sv @@
`include "varint_gap_decoder_core_defines.svh"

module vgd_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input vgd_pkg::vgd_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input vgd_pkg::vgd_out_t m_data
);
    import vgd_pkg::*;

    // Hold a stalled result
    `VGD_ASSERT_NEXT(a_hold_result, m_valid && !m_ready, m_valid && $stable(m_data))

    // Drop all results while in reset
    `VGD_ASSERT_ALWAYS(a_reset_clear, !aresetn, !m_valid)

    // With the result register empty and no new byte, the input side frees up
    `VGD_ASSERT_NEXT(a_drain_ready, !m_valid && !(s_valid && s_ready), s_ready)

    // A one-byte positive first edge comes out flagged as source plus magnitude
    `VGD_ASSERT_NEXT(a_first_edge,
        s_valid && s_ready && s_data.list_start && !s_data.code_byte[CONT_BIT]
            && !s_data.code_byte[SIGN_BIT] ##1 (!m_valid || m_ready),
        m_valid && m_data.first_of_list
            && (m_data.edge_value == $past(s_data.source_vertex, 2)
                + EDGE_BITS'($past(s_data.code_byte[FIRST_MAG_BITS-1:0], 2))))

endmodule

bind varint_gap_decoder_core vgd_checker u_vgd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ sim/varint_gap_decoder_core_tb.sv @@
module varint_gap_decoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vgd_pkg::*;

    // Decoded-edge predictor and the queue of edges still owed by the block.
    class edge_scoreboard;
        vertex_t    prev_edge;
        vertex_t    src_vertex;
        vertex_t    gap_bits;
        shift_t     gap_shift;
        bit         first_edge;
        bit         negative;
        bit         partial;
        vgd_out_t   expected_edges[$];
        int unsigned errors;

        function new();
            prev_edge  = '0;
            src_vertex = '0;
            gap_bits   = '0;
            gap_shift  = '0;
            first_edge = 1'b0;
            negative   = 1'b0;
            partial    = 1'b0;
            errors     = 0;
        endfunction

        // Advance the decode state by one accepted byte.
        function void note_byte(vgd_in_t item);
            logic [63:0] widened;
            vertex_t     decoded;
            vgd_out_t    result;
            if (item.list_start) begin
                src_vertex = item.source_vertex;
                first_edge = 1'b1;
                negative   = item.code_byte[SIGN_BIT];
                gap_bits   = vertex_t'(item.code_byte[FIRST_MAG_BITS-1:0]);
                gap_shift  = FIRST_SHIFT;
            end else begin
                if (!partial) begin
                    first_edge = 1'b0;
                    gap_bits   = '0;
                    gap_shift  = '0;
                end
                // Groups that land at or above the vertex width fall off.
                if (gap_shift < VERTEX_BITS) begin
                    widened  = 64'(item.code_byte[GROUP_BITS-1:0]) << gap_shift;
                    gap_bits = gap_bits | widened[VERTEX_BITS-1:0];
                end
                if (item.code_byte[CONT_BIT]) begin
                    if (gap_shift > SHIFT_MAX - GROUP_BITS)
                        gap_shift = SHIFT_MAX;
                    else
                        gap_shift = gap_shift + shift_t'(GROUP_BITS);
                end
            end
            if (item.code_byte[CONT_BIT]) begin
                partial = 1'b1;
                return;
            end
            if (first_edge)
                decoded = negative ? src_vertex - gap_bits : src_vertex + gap_bits;
            else
                decoded = prev_edge + gap_bits;
            prev_edge            = decoded;
            result.edge_value    = decoded;
            result.first_of_list = first_edge;
            expected_edges.push_back(result);
            first_edge = 1'b0;
            partial    = 1'b0;
            gap_bits   = '0;
            gap_shift  = '0;
        endfunction

        function void check_edge(vgd_out_t got);
            vgd_out_t want;
            if (expected_edges.size() == 0) begin
                $display("%0t: unexpected edge, value %h first %b",
                         $realtime, got.edge_value, got.first_of_list);
                errors++;
                return;
            end
            want = expected_edges.pop_front();
            if (got.edge_value !== want.edge_value) begin
                $display("%0t: edge_value expected %h actual %h",
                         $realtime, want.edge_value, got.edge_value);
                errors++;
            end
            if (got.first_of_list !== want.first_of_list) begin
                $display("%0t: first_of_list expected %b actual %b",
                         $realtime, want.first_of_list, got.first_of_list);
                errors++;
            end
        endfunction
    endclass

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    vgd_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    vgd_out_t m_data;

    edge_scoreboard sb = new();

    // Percent chance, per cycle, of a sender gap and of a receiver stall.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned bytes_sent     = 0;

    varint_gap_decoder_core u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side: check every accepted transaction, then pick the next
    // cycle's ready. One nonblocking write of m_ready per edge.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_edge(m_data);
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Offer one byte, idling first at the current rate, and hold it until
    // the block takes it. The scoreboard learns of it only on acceptance.
    task automatic send_code(input logic [7:0] code, input logic start,
                             input vertex_t src);
        vgd_in_t item;
        item.code_byte     = code;
        item.list_start    = start;
        item.source_vertex = src;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do
            @(posedge aclk);
        while (!s_ready);
        sb.note_byte(item);
        bytes_sent++;
    endtask

    // Send one varint of n_bytes bytes with random groups. With cut set the
    // last byte keeps its continue bit, leaving the edge unfinished.
    task automatic send_varint(input bit start, input vertex_t src,
                               input int unsigned n_bytes, input bit cut);
        logic [7:0] code;
        for (int unsigned i = 0; i < n_bytes; i++) begin
            code           = 8'($urandom);
            code[CONT_BIT] = cut || (i != n_bytes - 1);
            // Favor the single zero byte that stands for a zero gap.
            if (!start && n_bytes == 1 && !cut && $urandom_range(0, 3) == 0)
                code = 8'h00;
            send_code(code, start && i == 0,
                      (start && i == 0) ? src : vertex_t'($urandom));
        end
    endtask

    // One well-formed list with random content; now and then the last
    // edge is left hanging so the next list start has to discard it.
    task automatic send_random_list();
        vertex_t     src;
        int unsigned n_edges;
        int unsigned n_bytes;
        int unsigned pick;
        bit          truncate;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            src = '0;
        else if (pick == 1)
            src = '1;
        else
            src = vertex_t'($urandom);
        n_edges  = $urandom_range(1, 6);
        truncate = ($urandom_range(0, 9) == 0);
        for (int unsigned e = 0; e < n_edges; e++) begin
            pick = $urandom_range(0, 15);
            if (pick < 8)
                n_bytes = 1;
            else if (pick < 12)
                n_bytes = 2;
            else if (pick < 14)
                n_bytes = $urandom_range(3, 5);
            else
                n_bytes = $urandom_range(6, 12);
            send_varint(e == 0, src, n_bytes, truncate && e == n_edges - 1);
        end
    endtask

    // Hold the sender until every owed edge is out, then let the pipe empty.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.expected_edges.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        int unsigned send_pct[4]  = '{0, 75, 0, 25};
        int unsigned stall_pct[4] = '{0, 0, 75, 25};
        int unsigned phase_end;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Gaps before any list start add onto a previous edge of zero.
        send_code(8'h05, 1'b0, 32'hdead_beef);
        send_code(8'h00, 1'b0, 32'h0000_0001);
        // Largest positive first edge wraps past the top of the range.
        send_code(8'h3f, 1'b1, 32'hffff_ffff);
        send_code(8'h00, 1'b0, 32'h0);
        // Negative first edge wraps below zero, then a full 7-bit gap.
        send_code(8'h41, 1'b1, 32'h0000_0000);
        send_code(8'h7f, 1'b0, 32'hffff_ffff);
        // Over-long first edge: groups past bit 31 drop.
        send_code(8'hbf, 1'b1, 32'h8000_0000);
        send_code(8'hff, 1'b0, 32'h0);
        send_code(8'hff, 1'b0, 32'h0);
        send_code(8'hff, 1'b0, 32'h0);
        send_code(8'hff, 1'b0, 32'h0);
        send_code(8'h7f, 1'b0, 32'h0);
        // List start in the middle of an edge discards the partial edge.
        send_code(8'hff, 1'b1, 32'h1234_5678);
        send_code(8'h00, 1'b1, 32'haaaa_aaaa);
        // Gap long enough for the shift position to saturate.
        repeat (10) send_code(8'hff, 1'b0, 32'h0);
        send_code(8'h01, 1'b0, 32'h0);

        // Pause the sender until every owed edge has come out.
        drain();

        foreach (send_pct[p]) begin
            send_idle_pct  = send_pct[p];
            recv_stall_pct = stall_pct[p];
            phase_end      = bytes_sent + 410;
            while (bytes_sent < phase_end) begin
                if ($urandom_range(0, 9) == 0) begin
                    // Noise: random bytes, occasional stray list starts.
                    repeat ($urandom_range(1, 4))
                        send_code(8'($urandom), ($urandom_range(0, 3) == 0),
                                  vertex_t'($urandom));
                end else begin
                    send_random_list();
                end
            end
            drain();
        end

        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_edges.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/vgd_pkg.sv
src/vgd_in_stage.sv
src/vgd_decode.sv
src/vgd_out_stage.sv
src/varint_gap_decoder_core.sv
src/vgd_checker.sv
sim/varint_gap_decoder_core_tb.sv
